>>> rtl/dht_pkg.sv
package dht_pkg;

  // Phase codes of the frame receiver.
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_START = 2'd1;
  localparam logic [1:0] PH_RECV  = 2'd2;

  // Input operation codes.
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;

  // Status codes.
  localparam logic [1:0] ST_VALID = 2'd0;
  localparam logic [1:0] ST_SHORT = 2'd1;
  localparam logic [1:0] ST_CSUM  = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_START_LOW = 2'd0;
  localparam logic [1:0] REG_TIMEOUT   = 2'd1;
  localparam logic [1:0] REG_THRESHOLD = 2'd2;
  localparam logic [1:0] REG_MAX_TRANS = 2'd3;

  // Reset values of the configuration registers.
  localparam logic [19:0] START_LOW_RST = 20'd18000;
  localparam logic [7:0]  TIMEOUT_RST   = 8'd255;
  localparam logic [7:0]  THRESHOLD_RST = 8'd16;
  localparam logic [7:0]  MAX_TRANS_RST = 8'd85;

  localparam logic [7:0]  LEVEL_MAX     = 8'd255;
  localparam logic [7:0]  TRANS_MAX     = 8'd255;
  localparam logic [7:0]  FIRST_BIT_TR  = 8'd4;
  localparam logic [5:0]  FRAME_BITS    = 6'd40;
  localparam logic [15:0] HUM_LIMIT     = 16'd1000;
  localparam logic [14:0] TEMP_LIMIT    = 15'd1250;

  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] humidity;
    logic [12:0] temperature;
  } frame_res_t;

  // Multiply an 8-bit value by ten with two shifts and an add.
  function automatic logic [11:0] times_ten(input logic [7:0] v);
    logic [11:0] w;
    begin
      w = {4'd0, v};
      times_ten = (w << 3) + (w << 1);
    end
  endfunction

  // Checks and converts a complete frame.
  function automatic frame_res_t decode_frame(input logic [39:0] fb, input logic [5:0] nbits);
    logic [7:0]  b0, b1, b2, b3, b4;
    logic [7:0]  csum;
    logic [15:0] hum;
    logic [14:0] tmag;
    logic [11:0] hum_v;
    logic [12:0] tmag_v;
    frame_res_t  r;
    begin
      b0 = fb[39:32];
      b1 = fb[31:24];
      b2 = fb[23:16];
      b3 = fb[15:8];
      b4 = fb[7:0];
      csum = b0 + b1 + b2 + b3;
      hum = {b0, b1};
      tmag = {b2[6:0], b3};
      hum_v = (hum > HUM_LIMIT) ? times_ten(b0) : hum[11:0];
      tmag_v = (tmag > TEMP_LIMIT) ? {1'b0, times_ten(b2)} : tmag[12:0];
      r.status = ST_VALID;
      r.humidity = '0;
      r.temperature = '0;
      if (nbits < FRAME_BITS) begin
        r.status = ST_SHORT;
      end else if (csum != b4) begin
        r.status = ST_CSUM;
      end else begin
        r.humidity = hum_v;
        r.temperature = b2[7] ? (13'd0 - tmag_v) : tmag_v;
      end
      decode_frame = r;
    end
  endfunction

endpackage

>>> rtl/dht_single_wire_reader_unit.sv
// Channel   | Ports                         | Beat contents (lowest bit first)
// ----------+-------------------------------+-------------------------------------------
// input     | in_tvalid/in_tready/in_tdata  | tdata: pin_level; tuser: operation
// result    | out_tvalid/out_tready/out_tdata| drive_low, done_res, status, humidity,
//           |                               | temperature (signed)
// config    | cfg_valid/cfg_ready           | cfg_index, cfg_data (always ready)
//
// Every input beat yields exactly one result beat, one beat per cycle sustained while out_tready stays high.
// An accepted beat sits in the input register until the result register is free; then
// the receiver state is updated and the result register is loaded.
// The input register and the result register let a new beat enter while a result waits.
// Reset (rst_n low, synchronous) restores the register defaults and an idle receiver
// with the line released and assumed high.
module dht_single_wire_reader_unit
  import dht_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [0] pin_level, [7:1] zero
  input  logic        in_tuser,   // [0] operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [0] drive_low, [1] done_res, [3:2] status,
                                  // [15:4] humidity_tenths, [28:16] temperature_tenths
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_data
);

  // Configuration registers.
  logic [19:0] start_low_r;
  logic [7:0]  timeout_r;
  logic [7:0]  threshold_r;
  logic [7:0]  max_trans_r;

  // Input register.
  logic        s1_valid_r;
  logic        s1_op_r;
  logic        s1_pin_r;

  // Receiver state.
  logic [1:0]  phase_r,      phase_nxt;
  logic [19:0] start_cnt_r,  start_cnt_nxt;
  logic [7:0]  level_cnt_r,  level_cnt_nxt;
  logic        last_lvl_r,   last_lvl_nxt;
  logic [7:0]  trans_idx_r,  trans_idx_nxt;
  logic [5:0]  bit_cnt_r,    bit_cnt_nxt;
  logic [39:0] frame_r,      frame_nxt;

  // Result register.
  logic        out_valid_r;
  logic [31:0] out_data_r,   out_data_nxt;

  logic        out_free;
  logic        s1_fire;
  logic        drive_nxt;
  logic        done_nxt;
  logic [7:0]  limit;
  frame_res_t  fres;

  assign cfg_ready  = 1'b1;
  assign out_free   = !out_valid_r || out_tready;
  assign s1_fire    = s1_valid_r && out_free;
  assign in_tready  = !s1_valid_r || out_free;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign limit      = (max_trans_r == 8'd0) ? 8'd1 : max_trans_r;

  // One receiver step for the beat held in the input register.
  always_comb begin
    phase_nxt     = phase_r;
    start_cnt_nxt = start_cnt_r;
    level_cnt_nxt = level_cnt_r;
    last_lvl_nxt  = last_lvl_r;
    trans_idx_nxt = trans_idx_r;
    bit_cnt_nxt   = bit_cnt_r;
    frame_nxt     = frame_r;
    drive_nxt     = 1'b0;
    done_nxt      = 1'b0;
    if (s1_op_r == OP_START) begin
      frame_nxt     = '0;
      bit_cnt_nxt   = '0;
      trans_idx_nxt = '0;
      level_cnt_nxt = '0;
      last_lvl_nxt  = 1'b1;
      start_cnt_nxt = start_low_r;
      phase_nxt     = PH_START;
      drive_nxt     = 1'b1;
    end else if (phase_r == PH_START) begin
      // The tick that ends the low pulse releases the line and takes no sample.
      if (start_cnt_r > 20'd1) begin
        start_cnt_nxt = start_cnt_r - 20'd1;
        drive_nxt     = 1'b1;
      end else begin
        start_cnt_nxt = '0;
        phase_nxt     = PH_RECV;
      end
    end else if (phase_r == PH_RECV) begin
      if (s1_pin_r == last_lvl_r) begin
        if (level_cnt_r != LEVEL_MAX) begin
          level_cnt_nxt = level_cnt_r + 8'd1;
        end
        done_nxt = (level_cnt_nxt >= timeout_r);
      end else begin
        // Even transitions from the fifth on close a data bit's high time.
        if (trans_idx_r >= FIRST_BIT_TR && !trans_idx_r[0] && bit_cnt_r < FRAME_BITS) begin
          frame_nxt   = {frame_r[38:0], (level_cnt_r > threshold_r)};
          bit_cnt_nxt = bit_cnt_r + 6'd1;
        end
        if (trans_idx_r != TRANS_MAX) begin
          trans_idx_nxt = trans_idx_r + 8'd1;
        end
        level_cnt_nxt = '0;
        last_lvl_nxt  = s1_pin_r;
        done_nxt      = (trans_idx_nxt >= limit);
      end
      if (done_nxt) begin
        phase_nxt = PH_IDLE;
      end
    end
  end

  assign fres = decode_frame(frame_nxt, bit_cnt_nxt);

  always_comb begin
    out_data_nxt = '0;
    out_data_nxt[0] = drive_nxt;
    out_data_nxt[1] = done_nxt;
    if (done_nxt) begin
      out_data_nxt[3:2]   = fres.status;
      out_data_nxt[15:4]  = fres.humidity;
      out_data_nxt[28:16] = fres.temperature;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_low_r <= START_LOW_RST;
      timeout_r   <= TIMEOUT_RST;
      threshold_r <= THRESHOLD_RST;
      max_trans_r <= MAX_TRANS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_START_LOW: start_low_r <= cfg_data;
        REG_TIMEOUT:   timeout_r   <= cfg_data[7:0];
        REG_THRESHOLD: threshold_r <= cfg_data[7:0];
        REG_MAX_TRANS: max_trans_r <= cfg_data[7:0];
        default:       start_low_r <= start_low_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= PH_IDLE;
      start_cnt_r <= '0;
      level_cnt_r <= '0;
      last_lvl_r  <= 1'b1;
      trans_idx_r <= '0;
      bit_cnt_r   <= '0;
      frame_r     <= '0;
    end else begin
      if (in_tvalid && in_tready) begin
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_r <= 1'b1;
        phase_r     <= phase_nxt;
        start_cnt_r <= start_cnt_nxt;
        level_cnt_r <= level_cnt_nxt;
        last_lvl_r  <= last_lvl_nxt;
        trans_idx_r <= trans_idx_nxt;
        bit_cnt_r   <= bit_cnt_nxt;
        frame_r     <= frame_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers, no reset needed.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_op_r  <= in_tuser;
      s1_pin_r <= in_tdata[0];
    end
    if (s1_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_bit_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bit_cnt_r <= FRAME_BITS)
    else $error("bit counter passed the frame length");

  a_start_enters: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_op_r == OP_START |=> phase_r == PH_START && out_tdata[0])
    else $error("start beat did not begin the low pulse");

  a_not_done_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[1] |-> out_tdata[28:2] == 27'd0)
    else $error("frame fields set on a beat without a completed frame");

  a_done_released: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1] |-> !out_tdata[0] && phase_r == PH_IDLE)
    else $error("frame completed while driving the line or not idle");
`endif

endmodule

>>> sim/dht_reader_checker.sv
`timescale 1ns / 100ps

// Watches the three channels of the sensor frame decoder, keeps its own model of the
// receiver, and compares every result beat with the oldest predicted reading.
module dht_reader_checker
  import dht_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_data,
  output int          mismatches,
  output int          outstanding
);

  typedef struct packed {
    logic               drive_low;
    logic               done;
    logic [1:0]         status;
    logic [11:0]        humidity;
    logic signed [12:0] temperature;
  } reading_t;

  // Shadow copy of the configuration registers.
  logic [19:0] start_low_q;
  logic [7:0]  timeout_q;
  logic [7:0]  threshold_q;
  logic [7:0]  max_trans_q;

  // Shadow copy of the receiver state.
  logic [1:0]  rx_phase;
  logic [19:0] start_cnt;
  logic [7:0]  level_cnt;
  logic        prev_level;
  logic [7:0]  trans_idx;
  logic [5:0]  bit_cnt;
  logic [39:0] frame_q;

  reading_t expected_readings[$];

  // Ends the frame and fills in status, humidity and temperature.
  task automatic close_frame(inout reading_t r);
    logic [7:0] b0, b1, b2, b3, b4;
    logic [7:0] sum8;
    int hum;
    int tmag;
    int temp;
    b0 = frame_q[39:32];
    b1 = frame_q[31:24];
    b2 = frame_q[23:16];
    b3 = frame_q[15:8];
    b4 = frame_q[7:0];
    sum8 = b0 + b1 + b2 + b3;
    rx_phase = PH_IDLE;
    r.done = 1'b1;
    if (bit_cnt < 6'd40) begin
      r.status = ST_SHORT;
    end else if (sum8 != b4) begin
      r.status = ST_CSUM;
    end else begin
      hum = int'(b0) * 256 + int'(b1);
      if (hum > 1000) hum = int'(b0) * 10;
      tmag = int'(b2[6:0]) * 256 + int'(b3);
      if (tmag > 1250) tmag = int'(b2) * 10;
      temp = b2[7] ? -tmag : tmag;
      r.status = ST_VALID;
      r.humidity = 12'(hum);
      r.temperature = 13'(temp);
    end
  endtask

  // Advances the model by one input beat and returns the reading it causes.
  task automatic predict_reading(input logic op, input logic pin, output reading_t r);
    logic [7:0] limit;
    r = '0;
    if (op == OP_START) begin
      frame_q = '0;
      bit_cnt = '0;
      trans_idx = '0;
      level_cnt = '0;
      prev_level = 1'b1;
      start_cnt = start_low_q;
      rx_phase = PH_START;
      r.drive_low = 1'b1;
    end else if (rx_phase == PH_START) begin
      if (start_cnt > 20'd1) begin
        start_cnt = start_cnt - 20'd1;
        r.drive_low = 1'b1;
      end else begin
        start_cnt = '0;
        rx_phase = PH_RECV;
      end
    end else if (rx_phase == PH_RECV) begin
      if (pin == prev_level) begin
        if (level_cnt < 8'd255) level_cnt = level_cnt + 8'd1;
        if (level_cnt >= timeout_q) close_frame(r);
      end else begin
        if (trans_idx >= 8'd4 && !trans_idx[0] && bit_cnt < 6'd40) begin
          frame_q = {frame_q[38:0], (level_cnt > threshold_q)};
          bit_cnt = bit_cnt + 6'd1;
        end
        if (trans_idx < 8'd255) trans_idx = trans_idx + 8'd1;
        level_cnt = '0;
        prev_level = pin;
        limit = (max_trans_q == 8'd0) ? 8'd1 : max_trans_q;
        if (trans_idx >= limit) close_frame(r);
      end
    end
  endtask

  task automatic compare_field(input string name, input int want_v, input int got_v);
    if (want_v != got_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : monitor
    reading_t got;
    reading_t want;
    if (!rst_n) begin
      start_low_q = START_LOW_RST;
      timeout_q = TIMEOUT_RST;
      threshold_q = THRESHOLD_RST;
      max_trans_q = MAX_TRANS_RST;
      rx_phase = PH_IDLE;
      start_cnt = '0;
      level_cnt = '0;
      prev_level = 1'b1;
      trans_idx = '0;
      bit_cnt = '0;
      frame_q = '0;
      expected_readings.delete();
      mismatches = 0;
    end else begin
      // A result leaves only after its input beat has passed the input register, so the
      // compare comes before this edge's prediction is queued.
      if (out_tvalid && out_tready) begin
        got.drive_low = out_tdata[0];
        got.done = out_tdata[1];
        got.status = out_tdata[3:2];
        got.humidity = out_tdata[15:4];
        got.temperature = out_tdata[28:16];
        if (expected_readings.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, actual %h", $time, out_tdata);
          mismatches++;
        end else begin
          want = expected_readings.pop_front();
          compare_field("drive_low", want.drive_low, got.drive_low);
          compare_field("done", want.done, got.done);
          compare_field("status", want.status, got.status);
          compare_field("humidity", want.humidity, got.humidity);
          compare_field("temperature", int'(want.temperature), int'(got.temperature));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_START_LOW: start_low_q = cfg_data;
          REG_TIMEOUT:   timeout_q = cfg_data[7:0];
          REG_THRESHOLD: threshold_q = cfg_data[7:0];
          REG_MAX_TRANS: max_trans_q = cfg_data[7:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        predict_reading(in_tuser, in_tdata[0], want);
        expected_readings.push_back(want);
      end
    end
    outstanding <= expected_readings.size();
  end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps

// Top of the simulation for the single-wire sensor frame decoder. This module only makes
// stimulus and gives the verdict; the checker beside the block predicts every result
// beat and counts mismatches.
module testbench
  import dht_pkg::*;
();

  // The run is short (a few thousand beats); this bound is many times the slowest
  // correct run, including the long level timeouts of the extreme settings.
  localparam int RUN_LIMIT_NS  = 3_000_000;
  localparam int RANDOM_BEATS  = 1150;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;    // [0] pin_level, [7:1] zero
  logic        in_tuser = 1'b0;  // [0] operation
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;        // [0] drive_low, [1] done_res, [3:2] status,
                                 // [15:4] humidity_tenths, [28:16] temperature_tenths
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [19:0] cfg_data = '0;

  int mismatches;
  int outstanding;

  // Stimulus bookkeeping.
  int          beats_sent = 0;
  int          directed_end;
  int          episode;
  int          pick;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  logic [19:0] cur_start_low;
  logic [7:0]  cur_timeout;
  logic [7:0]  cur_threshold;
  logic [7:0]  hum_hi, hum_lo, temp_hi, temp_lo, csum_byte;
  logic [7:0]  pick_maxt;

  dht_single_wire_reader_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  dht_reader_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // The receiver stalls at random with the stall percentage of the current episode.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Hard stop in case the block hangs.
  initial begin
    #RUN_LIMIT_NS;
    $display("FAIL");
    $finish;
  end

  // Offers one beat and holds it until the block takes it. Afterward the sender may go
  // idle; if it does not, the next beat follows in the same step and tvalid simply
  // stays high.
  task automatic send_beat(input logic op, input logic pin);
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {7'd0, pin};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    beats_sent++;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  // Stops sending and waits until every predicted reading has come back. The checker
  // updates its count at the edge, so the first look waits for the next edge.
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // One register write beat; cfg_valid is left high for the caller to lower.
  task automatic put_reg(input logic [1:0] idx, input logic [19:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Writes all four registers once every predicted reading has come back.
  task automatic program_regs(input logic [19:0] start_low, input logic [7:0] tmo,
                              input logic [7:0] th, input logic [7:0] maxt);
    settle();
    put_reg(REG_START_LOW, start_low);
    put_reg(REG_TIMEOUT, {12'd0, tmo});
    put_reg(REG_THRESHOLD, {12'd0, th});
    put_reg(REG_MAX_TRANS, {12'd0, maxt});
    cfg_valid <= 1'b0;
    cur_start_low = start_low;
    cur_timeout = tmo;
    cur_threshold = th;
  endtask

  // Plays one sensor frame: a start beat, the low pulse with random (ignored) pin values,
  // then alternating levels starting low. High level number k (from the fourth level on)
  // carries data bit k, long for a one and short for a zero. The line then rests at its
  // last level until the timeout closes the frame.
  task automatic send_frame(input logic [39:0] payload, input int nseg);
    int   nstart;
    int   d;
    int   k;
    logic lvl;
    lvl = 1'b1;
    send_beat(OP_START, 1'($urandom_range(0, 1)));
    nstart = (cur_start_low == 20'd0) ? 1 : int'(cur_start_low);
    repeat (nstart) send_beat(OP_TICK, 1'($urandom_range(0, 1)));
    for (int s = 0; s < nseg; s++) begin
      lvl = s[0];
      k = (s - 3) / 2;
      if (s[0] && s >= 3 && k < 40) begin
        if (payload[39 - k]) begin
          d = int'(cur_threshold) + 2;
        end else begin
          d = 1 + $urandom_range(0, (cur_threshold > 8'd2) ? 2 : int'(cur_threshold));
        end
      end else begin
        d = (cur_timeout > 8'd1) ? $urandom_range(1, 2) : 1;
      end
      repeat (d) send_beat(OP_TICK, lvl);
    end
    repeat (int'(cur_timeout) + 1) send_beat(OP_TICK, lvl);
  endtask

  initial begin
    // Synchronous reset, applied once.
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. Sample ticks while idle must give all-zero results.
    send_beat(OP_TICK, 1'b0);
    send_beat(OP_TICK, 1'b1);
    // Start with the reset settings: the line is pulled low.
    send_beat(OP_START, 1'b0);
    send_beat(OP_TICK, 1'b1);
    send_beat(OP_TICK, 1'b0);
    // Longest start pulse, interrupted by a second start.
    program_regs(20'hFFFFF, 8'd255, 8'd16, 8'd85);
    send_beat(OP_START, 1'b1);
    send_beat(OP_TICK, 1'b1);
    send_beat(OP_TICK, 1'b0);
    send_beat(OP_START, 1'b0);
    // A zero start length acts as one; a zero timeout closes the frame on the first
    // tick at an unchanged level after the release tick.
    program_regs(20'd0, 8'd0, 8'd255, 8'd0);
    send_beat(OP_START, 1'b1);
    send_beat(OP_TICK, 1'b0);
    send_beat(OP_TICK, 1'b1);
    send_beat(OP_TICK, 1'b1);
    // A zero transition limit acts as one: the first edge ends a short frame.
    program_regs(20'd1, 8'd255, 8'd0, 8'd0);
    send_beat(OP_START, 1'b0);
    send_beat(OP_TICK, 1'b1);
    send_beat(OP_TICK, 1'b0);
    send_beat(OP_TICK, 1'b1);
    directed_end = beats_sent;

    // Random part: mostly complete frames with random content, some cut short, some
    // under extreme settings, and some pure noise with starts mixed in.
    episode = 0;
    while (beats_sent - directed_end < RANDOM_BEATS) begin
      case (episode % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
        default: begin send_idle_pct = 34; recv_stall_pct = 34; end
      endcase

      // Frame content: small upper bytes now and then so both the tenths and the
      // whole-unit readings occur, a random sign, and mostly a correct checksum.
      hum_hi = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 1)) hum_hi = 8'($urandom_range(0, 3));
      hum_lo = 8'($urandom_range(0, 255));
      temp_hi = 8'($urandom_range(0, 127));
      if ($urandom_range(0, 1)) temp_hi = 8'($urandom_range(0, 4));
      temp_hi[7] = 1'($urandom_range(0, 1));
      temp_lo = 8'($urandom_range(0, 255));
      csum_byte = hum_hi + hum_lo + temp_hi + temp_lo;
      if ($urandom_range(0, 99) < 20) csum_byte = 8'($urandom_range(0, 255));

      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        program_regs(20'($urandom_range(0, 3)), 8'($urandom_range(0, 6)),
                     8'($urandom_range(0, 4)), 8'($urandom_range(0, 20)));
        repeat ($urandom_range(20, 60)) begin
          send_beat(($urandom_range(0, 99) < 6) ? OP_START : OP_TICK,
                    1'($urandom_range(0, 1)));
        end
      end else if (pick < 22) begin
        // Highest threshold and timeout: a one bit cannot fit, so the level counter
        // runs up to its limit and the frame ends short.
        program_regs(20'($urandom_range(0, 1)), 8'd255, 8'($urandom_range(254, 255)),
                     8'd255);
        send_frame({hum_hi, hum_lo, temp_hi, temp_lo, csum_byte}, $urandom_range(3, 9));
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: pick_maxt = 8'd85;
          5:             pick_maxt = 8'd84;
          6, 7:          pick_maxt = 8'd255;
          8:             pick_maxt = 8'($urandom_range(1, 84));
          default:       pick_maxt = 8'($urandom_range(0, 255));
        endcase
        cur_threshold = 8'($urandom_range(0, 2));
        program_regs(20'($urandom_range(0, 4)),
                     ($urandom_range(0, 9) == 0) ? 8'd255
                                                 : cur_threshold + 8'($urandom_range(2, 4)),
                     cur_threshold, pick_maxt);
        send_frame({hum_hi, hum_lo, temp_hi, temp_lo, csum_byte},
                   ($urandom_range(0, 99) < 80) ? 85 + $urandom_range(0, 6)
                                                : $urandom_range(5, 84));
      end
      episode++;
    end

    // Drain, then wait before giving the verdict.
    settle();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> dht_single_wire_reader_unit.f
rtl/dht_pkg.sv
rtl/dht_single_wire_reader_unit.sv
sim/dht_reader_checker.sv
sim/testbench.sv
